@@ hw/rtl/jsu_pkg.sv @@
`default_nettype none

package jsu_pkg;

    // Error codes carried in the result's error_code field
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NOTSTR   = 3'd1,
        ERR_ESC      = 3'd2,
        ERR_HEX      = 3'd3,
        ERR_SUR      = 3'd4,
        ERR_UNTERM   = 3'd5
    } err_code_t;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ErrW   = 3;
    // tuser: byte_valid, string_done, error_code (lowest bit first)
    localparam int unsigned UserW  = 2 + ErrW;
    localparam int unsigned MaxRes = 4;

endpackage

`default_nettype wire

@@ hw/rtl/json_string_unescape_utf8.sv @@
// JSON string unescaper with UTF-8 output.
//
// Input channel (s_*): one source byte of JSON text per item in s_tdata;
// s_tlast marks the final byte of the available data.
// Result channel (m_*): one item per decoded content byte or event.
// m_tdata is the UTF-8 byte, m_tuser carries byte_valid, string_done and
// the error code, and m_tlast flags the final result caused by one input.
//
// The results of an input item appear in the cycle after it is accepted.
// The input takes one item per cycle while the receiver is ready and each
// item gives at most one result; an item that gives several results (up to
// four, from a \u escape) holds off the input until its last result is
// taken; the single result register drains one result per ready cycle.
//
// Reset (aresetn low, synchronous) returns the decoder to waiting for an
// opening quote and drops any pending results. When the receiver stalls,
// the current result holds steady and the input is held off once the
// results of the newest item are all that remain to deliver.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [jsu_pkg::ByteW-1:0]   s_tdata,   // [7:0] in_byte
    input  wire logic                        s_tlast,   // in_end
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [jsu_pkg::ByteW-1:0]        m_tdata,   // [7:0] out_byte
    output logic [jsu_pkg::UserW-1:0]        m_tuser,   // [0] byte_valid,
                                                        // [1] string_done,
                                                        // [4:2] error_code
    output logic                             m_tlast    // last_of_run
);

    typedef enum logic [2:0] {
        MODE_IDLE,   // waiting for opening quote
        MODE_STR,    // inside string
        MODE_ESC,    // after backslash
        MODE_HEX,    // collecting \u digits
        MODE_SBS,    // want backslash of low surrogate
        MODE_SU      // want u of low surrogate
    } mode_t;

    // All results of one input item
    typedef struct packed {
        logic [jsu_pkg::MaxRes-1:0][jsu_pkg::ByteW-1:0] bytes;
        logic [2:0]                                     cnt;
        logic                                           bv;
        logic                                           done;
        jsu_pkg::err_code_t                             err;
    } bundle_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hexdig_t;

    typedef struct packed {
        logic [jsu_pkg::MaxRes-1:0][jsu_pkg::ByteW-1:0] bytes;
        logic [2:0]                                     cnt;
    } utf8_t;

    function automatic hexdig_t hex_digit(input logic [7:0] c);
        hexdig_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= "0" && c <= "9") begin
            h.value = 4'(c - 8'h30);
        end else if (c >= "a" && c <= "f") begin
            h.value = 4'(c - 8'h57);
        end else if (c >= "A" && c <= "F") begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t u;
        u.bytes = '0;
        if (cp <= 21'h7F) begin
            u.cnt      = 3'd1;
            u.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            u.cnt      = 3'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            u.cnt      = 3'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.cnt      = 3'd4;
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  dcnt_reg, dcnt_next;
    logic [9:0]  hi_reg, hi_next;
    logic        low_reg, low_next;

    bundle_t     bundle_reg, bundle_next;
    logic        busy_reg;
    logic [1:0]  idx_reg;

    hexdig_t     hv;
    logic [15:0] hex_val;
    logic [20:0] cp_sel;
    utf8_t       enc;
    logic        is_ws;
    logic        last_res;
    logic        in_take, out_take;

    assign in_take  = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;

    // ---- decode of one source byte ----
    always_comb begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        dcnt_next   = dcnt_reg;
        hi_next     = hi_reg;
        low_next    = low_reg;
        bundle_next = '0;
        bundle_next.err = jsu_pkg::ERR_NONE;

        is_ws   = (s_tdata == 8'h20) || (s_tdata inside {[8'h09:8'h0D]});
        hv      = hex_digit(s_tdata);
        hex_val = {acc_reg[11:0], hv.value};
        // low half of a pair: 0x10000 + high bits and low 10 bits, unchecked
        cp_sel  = low_reg ? (21'h10000 + {1'b0, hi_reg, hex_val[9:0]})
                          : {5'd0, hex_val};
        enc     = utf8_encode(cp_sel);

        case (mode_reg)
            MODE_IDLE: begin
                if (s_tdata == "\"") begin
                    mode_next = MODE_STR;
                end else if (!is_ws) begin
                    bundle_next.cnt = 3'd1;
                    bundle_next.err = jsu_pkg::ERR_NOTSTR;
                end
            end
            MODE_STR: begin
                if (s_tdata == "\\") begin
                    mode_next = MODE_ESC;
                end else if (s_tdata == "\"") begin
                    bundle_next.cnt  = 3'd1;
                    bundle_next.done = 1'b1;
                    mode_next        = MODE_IDLE;
                end else begin
                    bundle_next.cnt      = 3'd1;
                    bundle_next.bv       = 1'b1;
                    bundle_next.bytes[0] = s_tdata;
                end
            end
            MODE_ESC: begin
                bundle_next.cnt = 3'd1;
                bundle_next.bv  = 1'b1;
                mode_next       = MODE_STR;
                case (s_tdata)
                    "n":               bundle_next.bytes[0] = 8'h0A;
                    "t":               bundle_next.bytes[0] = 8'h09;
                    "r":               bundle_next.bytes[0] = 8'h0D;
                    "b":               bundle_next.bytes[0] = 8'h08;
                    "f":               bundle_next.bytes[0] = 8'h0C;
                    "\\", "/", "\"":   bundle_next.bytes[0] = s_tdata;
                    "u": begin
                        bundle_next.cnt = 3'd0;
                        bundle_next.bv  = 1'b0;
                        mode_next       = MODE_HEX;
                        acc_next        = 16'd0;
                        dcnt_next       = 2'd0;
                        low_next        = 1'b0;
                    end
                    default: begin
                        bundle_next.bv  = 1'b0;
                        bundle_next.err = jsu_pkg::ERR_ESC;
                        mode_next       = MODE_IDLE;
                    end
                endcase
            end
            MODE_HEX: begin
                if (!hv.ok) begin
                    bundle_next.cnt = 3'd1;
                    bundle_next.err = jsu_pkg::ERR_HEX;
                    mode_next       = MODE_IDLE;
                end else begin
                    acc_next = hex_val;
                    if (dcnt_reg != 2'd3) begin
                        dcnt_next = dcnt_reg + 2'd1;
                    end else begin
                        dcnt_next = 2'd0;
                        if (!low_reg && hex_val >= 16'hD800 && hex_val <= 16'hDBFF) begin
                            hi_next   = hex_val[9:0];
                            mode_next = MODE_SBS;
                        end else begin
                            low_next          = 1'b0;
                            mode_next         = MODE_STR;
                            bundle_next.bytes = enc.bytes;
                            bundle_next.cnt   = enc.cnt;
                            bundle_next.bv    = 1'b1;
                        end
                    end
                end
            end
            MODE_SBS: begin
                if (s_tdata == "\\") begin
                    mode_next = MODE_SU;
                end else if (!is_ws) begin
                    bundle_next.cnt = 3'd1;
                    bundle_next.err = jsu_pkg::ERR_SUR;
                    mode_next       = MODE_IDLE;
                end
            end
            MODE_SU: begin
                if (s_tdata == "u") begin
                    mode_next = MODE_HEX;
                    acc_next  = 16'd0;
                    dcnt_next = 2'd0;
                    low_next  = 1'b1;
                end else if (!is_ws) begin
                    bundle_next.cnt = 3'd1;
                    bundle_next.err = jsu_pkg::ERR_SUR;
                    mode_next       = MODE_IDLE;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        // data ends inside a string: error rides on the last result
        if (s_tlast && mode_next != MODE_IDLE) begin
            bundle_next.err = (mode_next == MODE_SBS || mode_next == MODE_SU)
                              ? jsu_pkg::ERR_SUR : jsu_pkg::ERR_UNTERM;
            if (bundle_next.cnt == 3'd0) begin
                bundle_next.cnt = 3'd1;
            end
            mode_next = MODE_IDLE;
            low_next  = 1'b0;
            dcnt_next = 2'd0;
        end
    end

    // ---- result serializer ----
    assign last_res = (({1'b0, idx_reg} + 3'd1) == bundle_reg.cnt);
    assign s_tready = !busy_reg || (m_tready && last_res);
    assign m_tvalid = busy_reg;
    assign m_tdata  = bundle_reg.bytes[idx_reg];
    assign m_tlast  = last_res;
    assign m_tuser  = {(last_res ? bundle_reg.err : jsu_pkg::ERR_NONE),
                       bundle_reg.done, bundle_reg.bv};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 16'd0;
            dcnt_reg <= 2'd0;
            hi_reg   <= 10'd0;
            low_reg  <= 1'b0;
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            if (in_take) begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                dcnt_reg <= dcnt_next;
                hi_reg   <= hi_next;
                low_reg  <= low_next;
            end
            // a new bundle only loads once the previous one drains
            if (in_take && bundle_next.cnt != 3'd0) begin
                bundle_reg <= bundle_next;
                busy_reg   <= 1'b1;
                idx_reg    <= 2'd0;
            end else if (out_take) begin
                if (last_res) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/jsu_checker.sv @@
`default_nettype none

module jsu_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [jsu_pkg::ByteW-1:0]   m_tdata,
    input wire logic [jsu_pkg::UserW-1:0]   m_tuser,
    input wire logic                        m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed under stall");

    // nothing pending right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // errors and string end always close the run of one input item
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1] || m_tuser[4:2] != 3'd0) |-> m_tlast)
        else $error("error or done result not last of run");

    // a done marker carries no byte and no error
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == 8'd0
                                   && m_tuser[4:2] == 3'd0)
        else $error("malformed done result");

    // error codes in range; non-content results carry zero byte
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[4:2] <= 3'd5) && (m_tuser[0] || m_tdata == 8'd0))
        else $error("bad error code or stray byte");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
